/* design/threefry_2x32_20_block_defines.svh */
// Assertion macros shared by the Threefry-2x32 block.
// Expects clk and arst_n in the scope of use.
`ifndef THREEFRY_2X32_20_BLOCK_DEFINES_SVH
`define THREEFRY_2X32_20_BLOCK_DEFINES_SVH

// cond must hold at every edge outside reset
`define THF_AST_HOLD(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// ante at one edge implies cons at the next
`define THF_AST_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/thf_pkg.sv */
// Threefry-2x32 package: round count, rotation table, lane type, rotate helper.
// No dependencies.
`default_nettype none
package thf_pkg;
	localparam int ROUNDS = 20;
	localparam int RIDX_W = ($clog2(ROUNDS) < 3) ? 3 : $clog2(ROUNDS);
	localparam logic [31:0] PARITY_WORD = 32'h1BD1_1BDA;
	localparam logic [4:0] ROT_AMT [8] = '{5'd13, 5'd15, 5'd26, 5'd6,
	                                       5'd17, 5'd29, 5'd16, 5'd24};

	typedef struct packed {
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] ks0;
		logic [31:0] ks1;
		logic [31:0] ks2;
	} thf_lane_t;

	function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] n);
		logic [63:0] t;
		t = {v, v} << n;
		return t[63:32];
	endfunction
endpackage
`default_nettype wire

/* design/thf_seed_if.sv */
// Request channel carrying key and counter words.
// No dependencies.
`default_nettype none
interface thf_seed_if;
	logic        valid;
	logic        ready;
	logic [31:0] key_lo;
	logic [31:0] key_hi;
	logic [31:0] count_lo;
	logic [31:0] count_hi;

	modport source (output valid, key_lo, key_hi, count_lo, count_hi, input ready);
	modport sink (input valid, key_lo, key_hi, count_lo, count_hi, output ready);
endinterface
`default_nettype wire

/* design/thf_draw_if.sv */
// Result channel carrying the two random words.
// No dependencies.
`default_nettype none
interface thf_draw_if;
	logic        valid;
	logic        ready;
	logic [31:0] rand_lo;
	logic [31:0] rand_hi;

	modport source (output valid, rand_lo, rand_hi, input ready);
	modport sink (input valid, rand_lo, rand_hi, output ready);
endinterface
`default_nettype wire

/* design/thf_kinit.sv */
// Entry stage: builds the key schedule and adds the key to the counter.
// Depends on thf_pkg and thf_seed_if.
`default_nettype none
module thf_kinit
	import thf_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	thf_seed_if.sink   seed,
	output thf_lane_t  dn_lane,
	output logic       dn_valid,
	input  wire logic  dn_ready
);
	logic      vld_q;
	thf_lane_t lane_q;
	logic      adv;

	assign adv        = !vld_q || dn_ready;
	assign seed.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (adv) begin
			vld_q <= seed.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && seed.valid) begin
			lane_q.a   <= seed.count_lo + seed.key_lo;
			lane_q.b   <= seed.count_hi + seed.key_hi;
			lane_q.ks0 <= seed.key_lo;
			lane_q.ks1 <= seed.key_hi;
			lane_q.ks2 <= PARITY_WORD ^ seed.key_lo ^ seed.key_hi;
		end
	end

	assign dn_lane  = lane_q;
	assign dn_valid = vld_q;
endmodule
`default_nettype wire

/* design/thf_cell.sv */
// One Threefry round with optional key injection, registered, elastic handshake.
// Depends on thf_pkg.
`default_nettype none
module thf_cell
	import thf_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [RIDX_W-1:0] round_idx,
	input  wire thf_lane_t         up_lane,
	input  wire logic              up_valid,
	output logic                   up_ready,
	output thf_lane_t              dn_lane,
	output logic                   dn_valid,
	input  wire logic              dn_ready
);
	logic          vld_q;
	thf_lane_t     lane_q;
	thf_lane_t     nxt;
	logic          adv;
	logic [RIDX_W:0] rp1;
	logic [31:0]   inj;
	logic [31:0]   a1;
	logic [31:0]   b1;

	assign adv      = !vld_q || dn_ready;
	assign up_ready = adv;
	assign rp1      = {1'b0, round_idx} + {{RIDX_W{1'b0}}, 1'b1};
	assign inj      = {{(31 - RIDX_W + 2){1'b0}}, rp1[RIDX_W:2]};

	always_comb begin
		a1  = up_lane.a + up_lane.b;
		b1  = rotl32(up_lane.b, ROT_AMT[round_idx[2:0]]) ^ a1;
		nxt = up_lane;
		nxt.a = a1;
		nxt.b = b1;
		if (rp1[1:0] == 2'b00) begin
			// key words rotate so the next injection again reads ks1/ks2
			nxt.a   = a1 + up_lane.ks1;
			nxt.b   = b1 + up_lane.ks2 + inj;
			nxt.ks0 = up_lane.ks1;
			nxt.ks1 = up_lane.ks2;
			nxt.ks2 = up_lane.ks0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (adv) begin
			vld_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && up_valid) begin
			lane_q <= nxt;
		end
	end

	assign dn_lane  = lane_q;
	assign dn_valid = vld_q;
endmodule
`default_nettype wire

/* design/threefry_2x32_20_block.sv */
// Threefry-2x32 top level: entry stage followed by a chain of round cells.
// Depends on thf_pkg, thf_seed_if, thf_draw_if, thf_kinit, thf_cell, threefry_2x32_20_block_defines.svh.
//
// channel  dir  fields                               handshake
// seed     in   key_lo key_hi count_lo count_hi      valid/ready
// draw     out  rand_lo rand_hi                      valid/ready
//
// One request per cycle sustained while draw is ready; stages are the entry add, then one cell per round.
// Every stage holds its own valid bit, so bubbles close up while draw stalls.
// The last cell's register is the output register.
// Reset clears only valid bits; no clearing pass.
`default_nettype none
`include "threefry_2x32_20_block_defines.svh"
module threefry_2x32_20_block
	import thf_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	thf_seed_if.sink   seed,
	thf_draw_if.source draw
);
	thf_lane_t lane [ROUNDS+1];
	logic      vld  [ROUNDS+1];
	logic      rdy  [ROUNDS+1];

	thf_kinit u_kinit (
		.clk      (clk),
		.arst_n   (arst_n),
		.seed     (seed),
		.dn_lane  (lane[0]),
		.dn_valid (vld[0]),
		.dn_ready (rdy[0])
	);

	for (genvar r = 0; r < ROUNDS; r++) begin : g_cell
		thf_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.round_idx (RIDX_W'(r)),
			.up_lane   (lane[r]),
			.up_valid  (vld[r]),
			.up_ready  (rdy[r]),
			.dn_lane   (lane[r+1]),
			.dn_valid  (vld[r+1]),
			.dn_ready  (rdy[r+1])
		);
	end

	assign rdy[ROUNDS] = draw.ready;
	assign draw.valid  = vld[ROUNDS];
	assign draw.rand_lo = lane[ROUNDS].a;
	assign draw.rand_hi = lane[ROUNDS].b;

	`THF_AST_HOLD(a_stall_needs_full, seed.ready || vld[0], "entry stalled while empty")
	`THF_AST_HOLD(a_ready_chain, !draw.ready || seed.ready, "ready chain broken")
	`THF_AST_NEXT(a_entry_moves, vld[0] && rdy[0], vld[1], "entry request lost")
endmodule
`default_nettype wire
